// File: rtl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; used by every other file of the block except cbm_rsp_if.
package cbm_pkg;

   localparam int WORK_RAM_BYTES = 8192;
   localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);

   typedef logic [1:0] func_type;
   localparam func_type FUNC_CPU_WRITE = 2'd0;
   localparam func_type FUNC_CPU_READ  = 2'd1;
   localparam func_type FUNC_PPU_FETCH = 2'd2;
   localparam func_type FUNC_TICK      = 2'd3;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_PRG_MASK = 2'd0;
   localparam csr_index_type CSR_PRG_LAST = 2'd1;
   localparam csr_index_type CSR_CHR_MASK = 2'd2;

   localparam logic [15:0] ADDR_IRQ_OFF   = 16'hC002;
   localparam logic [15:0] ADDR_IRQ_ON    = 16'hC003;
   localparam logic [15:0] ADDR_IRQ_LOAD  = 16'hC005;
   localparam logic [15:0] ADDR_MIRROR    = 16'hD001;
   localparam logic [13:0] ADDR_PRG_PAGE  = 14'h2000;   // 0x8000 >> 2
   localparam logic [12:0] ADDR_CHR_PAGE  = 13'h1200;   // 0x9000 >> 3
   localparam logic [2:0]  ADDR_WRAM_PAGE = 3'b011;     // 0x6000-0x7FFF
   localparam logic [8:0]  LAST_VISIBLE_LINE = 9'd239;

   typedef struct packed {
      func_type    func;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [8:0]  line;
      logic        display_on;
   } item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        read_hit;
      logic [20:0] prg_rom_addr;
      logic        prg_hit;
      logic [17:0] chr_rom_addr;
      logic        mirror_horizontal;
      logic        irq;
   } result_type;

endpackage

// File: rtl/cbm_req_if.sv
// Request channel: valid/ready handshake with one bus item per beat.
// Depends on cbm_pkg.
interface cbm_req_if;
   logic               valid;
   logic               ready;
   cbm_pkg::func_type  func;
   logic [15:0]        addr;
   logic [7:0]         data;
   logic [8:0]         line;
   logic               display_on;

   modport source (output valid, func, addr, data, line, display_on, input ready);
   modport sink   (input valid, func, addr, data, line, display_on, output ready);
endinterface

// File: rtl/cbm_rsp_if.sv
// Response channel: valid/ready handshake with one result per beat.
// No dependencies.
interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        read_hit;
   logic [20:0] prg_rom_addr;
   logic        prg_hit;
   logic [17:0] chr_rom_addr;
   logic        mirror_horizontal;
   logic        irq;

   modport source (output valid, read_data, read_hit, prg_rom_addr, prg_hit,
                   chr_rom_addr, mirror_horizontal, irq, input ready);
   modport sink   (input valid, read_data, read_hit, prg_rom_addr, prg_hit,
                   chr_rom_addr, mirror_horizontal, irq, output ready);
endinterface

// File: rtl/cbm_wram.sv
// 8 KB work RAM, one write and one registered read port.
// Depends on cbm_pkg.
module cbm_wram (
   input  logic                        clock,
   input  logic                        we,
   input  logic                        re,
   input  logic [cbm_pkg::WRAM_AW-1:0] addr,
   input  logic [7:0]                  wdata,
   output logic [7:0]                  rdata_ff
);
   logic [7:0] mem [cbm_pkg::WORK_RAM_BYTES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end
endmodule

// File: rtl/cbm_core.sv
// Mapper state (banks, mirroring, scanline counter, CSRs) and address translation.
// Depends on cbm_pkg.
module cbm_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  cbm_pkg::item_type      item,
   input  logic [7:0]             wram_rdata,
   input  logic                   csr_we,
   input  cbm_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata,
   output cbm_pkg::result_type    res
);
   logic [7:0] prg_mask_ff, prg_last_ff, chr_mask_ff;
   logic [7:0] prg_bank_ff [3];
   logic [7:0] chr_bank_ff [8];
   logic       mirror_ff, mirror_in;
   logic [7:0] count_ff, count_in;
   logic       enable_ff, enable_in;
   logic       pending_ff, pending_in;
   logic [7:0] count_dec;
   logic       is_write, wram_page, prg_wr, chr_wr;
   logic [7:0] prg_bank;
   logic [7:0] chr_bank;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_mask_ff <= 8'hFF;
         prg_last_ff <= 8'hFF;
         chr_mask_ff <= 8'hFF;
      end else if (csr_we) begin
         unique case (csr_index)
            cbm_pkg::CSR_PRG_MASK: prg_mask_ff <= csr_wdata;
            cbm_pkg::CSR_PRG_LAST: prg_last_ff <= csr_wdata;
            cbm_pkg::CSR_CHR_MASK: chr_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign is_write  = item.func == cbm_pkg::FUNC_CPU_WRITE;
   assign wram_page = item.addr[15:13] == cbm_pkg::ADDR_WRAM_PAGE;
   assign prg_wr    = is_write && item.addr[15:2] == cbm_pkg::ADDR_PRG_PAGE
                      && item.addr[1:0] != 2'd3;
   assign chr_wr    = is_write && item.addr[15:3] == cbm_pkg::ADDR_CHR_PAGE;
   assign count_dec = count_ff - 8'd1;

   // post-beat values of the control state
   always_comb begin
      mirror_in  = mirror_ff;
      count_in   = count_ff;
      enable_in  = enable_ff;
      pending_in = pending_ff;
      if (is_write) begin
         if (item.addr == cbm_pkg::ADDR_IRQ_OFF) begin
            enable_in  = 1'b0;
            pending_in = 1'b0;
         end
         if (item.addr == cbm_pkg::ADDR_IRQ_ON) begin
            enable_in = 1'b1;
         end
         if (item.addr == cbm_pkg::ADDR_IRQ_LOAD) begin
            count_in = item.data;
         end
         if (item.addr == cbm_pkg::ADDR_MIRROR) begin
            mirror_in = item.data[0];
         end
      end else if (item.func == cbm_pkg::FUNC_TICK && item.line <= cbm_pkg::LAST_VISIBLE_LINE
                   && item.display_on && enable_ff) begin
         count_in = count_dec;
         if (count_dec == 8'd0) begin
            pending_in = 1'b1;
            enable_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff  <= 1'b0;
         count_ff   <= 8'd0;
         enable_ff  <= 1'b0;
         pending_ff <= 1'b0;
         for (int i = 0; i < 3; i++) prg_bank_ff[i] <= 8'd0;
         for (int i = 0; i < 8; i++) chr_bank_ff[i] <= 8'd0;
      end else if (go) begin
         mirror_ff  <= mirror_in;
         count_ff   <= count_in;
         enable_ff  <= enable_in;
         pending_ff <= pending_in;
         if (prg_wr) begin
            prg_bank_ff[item.addr[1:0]] <= item.data;
         end
         if (chr_wr) begin
            chr_bank_ff[item.addr[2:0]] <= item.data;
         end
      end
   end

   assign prg_bank = (item.addr[14:13] == 2'd3) ? prg_last_ff
                     : (prg_bank_ff[item.addr[14:13]] & prg_mask_ff);
   assign chr_bank = chr_bank_ff[item.addr[12:10]] & chr_mask_ff;

   always_comb begin
      res = '0;
      unique case (item.func)
         cbm_pkg::FUNC_CPU_READ: begin
            if (wram_page) begin
               res.read_hit  = 1'b1;
               res.read_data = wram_rdata;
            end else if (item.addr[15]) begin
               res.prg_hit      = 1'b1;
               res.prg_rom_addr = {prg_bank, item.addr[12:0]};
            end
         end
         cbm_pkg::FUNC_PPU_FETCH: res.chr_rom_addr = {chr_bank, item.addr[9:0]};
         default: ;
      endcase
      res.mirror_horizontal = mirror_in;
      res.irq               = pending_in;
   end
endmodule

// File: rtl/cartridge_bank_mapper_scanline_irq.sv
// Cartridge bank mapper with scanline IRQ counter: top level.
// Request beat registered in stage 1, then result in the response register; one beat per cycle unless rsp stalls.
// Work RAM read/written at request accept; banks and counter updated in stage 1.
// Synchronous reset clears handshake, bank, mirroring and IRQ state; CSRs to 0xFF.
// Work RAM is not cleared and needs no clearing pass.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if, cbm_wram, cbm_core.
module cartridge_bank_mapper_scanline_irq (
   input  logic                   clock,
   input  logic                   reset,
   cbm_req_if.sink                req_chan,
   cbm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  cbm_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata
);
   logic                s1_valid_ff, s1_valid_in;
   cbm_pkg::item_type   s1_item_ff, req_item;
   logic                rsp_valid_ff, rsp_valid_in;
   cbm_pkg::result_type rsp_ff, core_res;
   logic                accept, s1_go;
   logic [7:0]          wram_rdata;

   assign req_item = '{func: req_chan.func, addr: req_chan.addr, data: req_chan.data,
                       line: req_chan.line, display_on: req_chan.display_on};

   assign s1_go          = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!s1_valid_ff || s1_go);
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (s1_go) begin
         rsp_ff <= core_res;
      end
   end

   cbm_wram u_wram (
      .clock    (clock),
      .we       (accept && req_chan.func == cbm_pkg::FUNC_CPU_WRITE
                 && req_chan.addr[15:13] == cbm_pkg::ADDR_WRAM_PAGE),
      .re       (accept),
      .addr     (req_chan.addr[cbm_pkg::WRAM_AW-1:0]),
      .wdata    (req_chan.data),
      .rdata_ff (wram_rdata)
   );

   cbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .go         (s1_go),
      .item       (s1_item_ff),
      .wram_rdata (wram_rdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .res        (core_res)
   );

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.read_data         = rsp_ff.read_data;
   assign rsp_chan.read_hit          = rsp_ff.read_hit;
   assign rsp_chan.prg_rom_addr      = rsp_ff.prg_rom_addr;
   assign rsp_chan.prg_hit           = rsp_ff.prg_hit;
   assign rsp_chan.chr_rom_addr      = rsp_ff.chr_rom_addr;
   assign rsp_chan.mirror_horizontal = rsp_ff.mirror_horizontal;
   assign rsp_chan.irq               = rsp_ff.irq;

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.read_hit && rsp_ff.prg_hit))
      else $error("work RAM and PRG hit on one beat");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result beat without a stage 1 item");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stalled stage 1 item lost or changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !s1_go)
      else $error("result register overwritten while stalled");
endmodule
